FILE: sv/crb2d_pkg.sv
package crb2d_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 32;

  localparam int WORD_W     = 32;
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SLOT_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W     = SLOT_W + ROW_W;
  localparam int RCNT_W     = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W     = $clog2(MAX_COLS + 1);
  localparam int RUN_W      = (RCNT_W > CCNT_W) ? RCNT_W : CCNT_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = CFG_IDX_W'(1);

  localparam logic [2:0] OP_WRITE       = 3'd0;
  localparam logic [2:0] OP_READ_WORD   = 3'd1;
  localparam logic [2:0] OP_ROW_ORDERED = 3'd2;
  localparam logic [2:0] OP_ROW_SLOT    = 3'd3;
  localparam logic [2:0] OP_READ_COLUMN = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [3:0]        row_index;
    logic [4:0]        age;
    logic [WORD_W-1:0] sample_value;
    logic              column_done;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              last_of_run;
    logic              index_error;
  } out_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic fetch;
    logic push;
    logic advance;
  } ctl_cmd_t;

  typedef struct packed {
    logic new_write;
    logic new_err;
    logic run_last;
    logic clear_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [RCNT_W-1:0] eff_rows_f(input logic [4:0] v);
    logic [RCNT_W-1:0] r;
    if (v == 5'd0) begin
      r = RCNT_W'(1);
    end else if (int'(v) > MAX_ROWS) begin
      r = RCNT_W'(MAX_ROWS);
    end else begin
      r = RCNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [CCNT_W-1:0] eff_cols_f(input logic [5:0] v);
    logic [CCNT_W-1:0] r;
    if (v == 6'd0) begin
      r = CCNT_W'(1);
    end else if (int'(v) > MAX_COLS) begin
      r = CCNT_W'(MAX_COLS);
    end else begin
      r = CCNT_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: sv/crb2d_ctl.sv
module crb2d_ctl import crb2d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_PUSH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && !status.new_write) begin
          state_next = status.new_err ? S_PUSH : S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (status.out_free) begin
          cmd.push = 1'b1;
          if (status.run_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_FETCH;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/crb2d_dp.sv
module crb2d_dp import crb2d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  ctl_cmd_t              cmd,
  output dp_status_t            status
);

  logic [WORD_W-1:0] mem [1 << ADDR_W];
  logic [WORD_W-1:0] rdata;

  logic [RCNT_W-1:0] eff_rows;
  logic [CCNT_W-1:0] eff_cols;
  logic [SLOT_W-1:0] write_slot;
  logic [ADDR_W-1:0] clr_addr;

  logic [SLOT_W-1:0] cur_slot;
  logic [ROW_W-1:0]  cur_row;
  logic [RUN_W-1:0]  idx;
  logic [RUN_W-1:0]  run_len;
  logic              step_slot;
  logic              step_row;
  logic              err;

  logic              row_ok;
  logic              age_ok;
  logic              new_err;
  logic [CCNT_W:0]   age_sum;
  logic [SLOT_W-1:0] age_slot;
  logic [SLOT_W-1:0] write_slot_inc;
  logic [SLOT_W-1:0] cur_slot_inc;
  logic [CCNT_W-1:0] cfg_cols;
  logic              mem_we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic              run_last;
  logic              out_free;

  assign row_ok = int'(in_data.row_index) < int'(eff_rows);
  assign age_ok = int'(in_data.age) < int'(eff_cols);

  always_comb begin
    unique case (in_data.op)
      OP_WRITE:       new_err = 1'b0;
      OP_READ_WORD:   new_err = !row_ok || !age_ok;
      OP_ROW_ORDERED: new_err = !row_ok;
      OP_ROW_SLOT:    new_err = !row_ok;
      OP_READ_COLUMN: new_err = !age_ok;
      default:        new_err = 1'b1;
    endcase
  end

  assign age_sum  = (CCNT_W+1)'(write_slot) + (CCNT_W+1)'(eff_cols) - (CCNT_W+1)'(1)
                    - (CCNT_W+1)'(in_data.age);
  assign age_slot = (int'(age_sum) >= int'(eff_cols)) ?
                    SLOT_W'(age_sum - (CCNT_W+1)'(eff_cols)) : SLOT_W'(age_sum);

  assign write_slot_inc = (int'(write_slot) + 1 == int'(eff_cols)) ? '0 :
                          write_slot + SLOT_W'(1);
  assign cur_slot_inc   = (int'(cur_slot) + 1 == int'(eff_cols)) ? '0 :
                          cur_slot + SLOT_W'(1);
  assign cfg_cols       = eff_cols_f(cfg_data[5:0]);

  assign mem_we = cmd.clear_step || (cmd.accept && in_data.op == OP_WRITE && row_ok);
  assign waddr  = cmd.clear_step ? clr_addr : {write_slot, ROW_W'(in_data.row_index)};
  assign wdata  = cmd.clear_step ? '0 : in_data.sample_value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.fetch) begin
      rdata <= mem[{cur_slot, cur_row}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_rows   <= RCNT_W'(MAX_ROWS);
      eff_cols   <= CCNT_W'(MAX_COLS);
      write_slot <= '0;
      clr_addr   <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cfg_we) begin
        if (cfg_index == REG_ROW_COUNT) begin
          eff_rows <= eff_rows_f(cfg_data[4:0]);
        end else if (cfg_index == REG_COLUMN_COUNT) begin
          eff_cols <= cfg_cols;
          if (int'(write_slot) >= int'(cfg_cols)) begin
            write_slot <= '0;
          end
        end
      end else if (cmd.accept && in_data.op == OP_WRITE && in_data.column_done) begin
        write_slot <= write_slot_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      err <= new_err;
      idx <= '0;
      unique case (in_data.op)
        OP_READ_WORD: begin
          cur_slot  <= age_slot;
          cur_row   <= ROW_W'(in_data.row_index);
          run_len   <= RUN_W'(1);
          step_slot <= 1'b0;
          step_row  <= 1'b0;
        end
        OP_ROW_ORDERED: begin
          cur_slot  <= write_slot;
          cur_row   <= ROW_W'(in_data.row_index);
          run_len   <= RUN_W'(eff_cols);
          step_slot <= 1'b1;
          step_row  <= 1'b0;
        end
        OP_ROW_SLOT: begin
          cur_slot  <= '0;
          cur_row   <= ROW_W'(in_data.row_index);
          run_len   <= RUN_W'(eff_cols);
          step_slot <= 1'b1;
          step_row  <= 1'b0;
        end
        OP_READ_COLUMN: begin
          cur_slot  <= age_slot;
          cur_row   <= '0;
          run_len   <= RUN_W'(eff_rows);
          step_slot <= 1'b0;
          step_row  <= 1'b1;
        end
        default: begin
          cur_slot  <= age_slot;
          cur_row   <= ROW_W'(in_data.row_index);
          run_len   <= RUN_W'(1);
          step_slot <= 1'b0;
          step_row  <= 1'b0;
        end
      endcase
    end else if (cmd.advance) begin
      idx <= idx + RUN_W'(1);
      if (step_slot) begin
        cur_slot <= cur_slot_inc;
      end
      if (step_row) begin
        cur_row <= cur_row + ROW_W'(1);
      end
    end
  end

  assign run_last = err || (int'(idx) + 1 == int'(run_len));
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data.read_data   <= err ? '0 : rdata;
      out_data.last_of_run <= run_last;
      out_data.index_error <= err;
    end
  end

  assign status.new_write  = in_data.op == OP_WRITE;
  assign status.new_err    = new_err;
  assign status.run_last   = run_last;
  assign status.clear_last = &clr_addr;
  assign status.out_free   = out_free;

endmodule

FILE: sv/column_ring_buffer_2d_unit.sv
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_we                 cfg_index, cfg_data
// in        in         in_valid / in_ready    in_data  (in_t)
// out       out        out_valid / out_ready  out_data (out_t)
//
// A word write completes on acceptance. A read is accepted, then each result takes a
// memory read (S_FETCH) and an output load (S_PUSH); an error result skips the read.
// The word store has a registered read, so each result is fetched before it is loaded.
// After reset the store is swept to zero, one word a cycle, over all 2**ADDR_W words
// (512 at the default sizes); in_ready stays low during the sweep.
// A stalled output holds its result; the run pauses until out_ready returns.
module column_ring_buffer_2d_unit import crb2d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  crb2d_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  crb2d_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: sv/crb2d_checker.sv
module crb2d_checker import crb2d_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_reset_no_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_reset_sweep: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input accepted before store sweep");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  a_error_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.index_error |-> out_data.read_data == '0 && out_data.last_of_run)
    else $error("error result not zero or not last");

endmodule

bind column_ring_buffer_2d_unit crb2d_checker u_crb2d_checker (.*);
